>>> hdl/motor_start_pid_sequencer_core_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on clk and
// is held off while rst_n is low.
`ifndef MOTOR_START_PID_SEQUENCER_CORE_MACROS_SVH
`define MOTOR_START_PID_SEQUENCER_CORE_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define MSPS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// When the trigger is seen, the consequence holds at the same edge.
`define MSPS_ASSERT_IMPLIES(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("implication violated");

`endif

>>> hdl/msps_pkg.sv
`default_nettype none
package msps_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  KICK_POWER_RST = 8'd200;
  localparam logic [7:0]  HOLD_POWER_RST = 8'd150;
  localparam logic [15:0] SETTLE_MS_RST  = 16'd100;
  localparam logic [15:0] ZERO_BAND_RST  = 16'd65;

  localparam logic [17:0] ACC_MAX = 18'd65280;

  // Configuration register indexes.
  localparam logic [1:0] REG_KICK_POWER = 2'd0;
  localparam logic [1:0] REG_HOLD_POWER = 2'd1;
  localparam logic [1:0] REG_SETTLE_MS  = 2'd2;
  localparam logic [1:0] REG_ZERO_BAND  = 2'd3;

  // Item mode codes on the input tuser.
  localparam logic [1:0] MODE_SPEED = 2'd0;
  localparam logic [1:0] MODE_POWER = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SPEED_ZERO,
    CMD_SPEED_SET,
    CMD_POWER,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] speed;
    logic [8:0]  power;
    logic [31:0] count;
    logic [31:0] now;
    logic        pid_ready;
    logic [16:0] delta;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  kick_power;
    logic [7:0]  hold_power;
    logic [15:0] settle_ms;
    logic [15:0] zero_band;
  } cfg_t;

endpackage
`default_nettype wire

>>> hdl/msps_front.sv
`default_nettype none
module msps_front
  import msps_pkg::*;
(
  input  wire logic [1:0]   mode,
  input  wire logic [127:0] payload,
  input  wire logic [15:0]  zero_band,
  output cmd_t              cmd
);

  logic signed [31:0] speed;
  logic signed [32:0] speed_x;
  logic signed [32:0] band_x;
  logic               in_band;
  logic [8:0]         power_raw;

  assign speed     = $signed(payload[31:0]);
  assign speed_x   = 33'(speed);
  assign band_x    = $signed({17'd0, zero_band});
  assign in_band   = (speed_x > -band_x) && (speed_x < band_x);
  assign power_raw = payload[40:32];

  always_comb begin
    cmd.speed     = payload[31:0];
    // -256 is outside the motor range and saturates to -255.
    cmd.power     = (power_raw == 9'h100) ? 9'h101 : power_raw;
    cmd.count     = payload[73:42];
    cmd.now       = payload[105:74];
    cmd.pid_ready = payload[106];
    cmd.delta     = payload[123:107];
    case (mode)
      MODE_SPEED: cmd.kind = in_band ? CMD_SPEED_ZERO : CMD_SPEED_SET;
      MODE_POWER: cmd.kind = CMD_POWER;
      MODE_TICK:  cmd.kind = payload[41] ? CMD_TICK : CMD_NOP;
      default:    cmd.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/msps_queue.sv
`default_nettype none
module msps_queue
  import msps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`include "motor_start_pid_sequencer_core_macros.svh"

  `MSPS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH))
  `MSPS_ASSERT_IMPLIES(a_pop_moves_rd, $past(do_pop) && $past(rst_n), rd_ptr_r != $past(rd_ptr_r) || DEPTH == 1)
  `MSPS_ASSERT_IMPLIES(a_empty_ptrs, count_r == '0, rd_ptr_r == wr_ptr_r)

endmodule
`default_nettype wire

>>> hdl/msps_back.sv
`default_nettype none
module msps_back
  import msps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_data
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_KICK   = 3'd2,
    PH_SETTLE = 3'd3,
    PH_PID    = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] target_r, target_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic [31:0] start_count_r, start_count_nxt;
  logic [16:0] accum_r, accum_nxt;
  logic [8:0]  motor_r, motor_nxt;
  logic        out_valid_r;
  logic        written_r, written_nxt;
  logic        updated_r, updated_nxt;

  logic signed [17:0] sum;
  logic signed [17:0] clamped;
  logic [17:0]        neg_mag;
  logic               target_pos;
  logic [8:0]         pid_motor;
  logic [31:0]        elapsed;

  assign cmd_pop    = cmd_valid && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_data   = {2'b00, target_r, phase_r, updated_r, written_r, motor_r};

  assign target_pos = !target_r[31] && (target_r != '0);
  assign sum        = $signed({accum_r[16], accum_r}) + $signed({cmd.delta[16], cmd.delta});
  assign elapsed    = cmd.now - start_time_r;

  // Clamp the accumulator to the half range set by the target sign, then
  // truncate the Q8.8 value toward zero.
  always_comb begin
    if (target_pos) begin
      if (sum < 0) begin
        clamped = '0;
      end else if (sum > $signed(ACC_MAX)) begin
        clamped = $signed(ACC_MAX);
      end else begin
        clamped = sum;
      end
    end else begin
      if (sum > 0) begin
        clamped = '0;
      end else if (sum < -$signed(ACC_MAX)) begin
        clamped = -$signed(ACC_MAX);
      end else begin
        clamped = sum;
      end
    end
    neg_mag = 18'(-clamped);
    if (target_pos) begin
      pid_motor = {1'b0, clamped[15:8]};
    end else begin
      pid_motor = 9'(-{1'b0, neg_mag[15:8]});
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    target_nxt      = target_r;
    start_time_nxt  = start_time_r;
    start_count_nxt = start_count_r;
    accum_nxt       = accum_r;
    motor_nxt       = motor_r;
    written_nxt     = 1'b0;
    updated_nxt     = 1'b0;
    case (cmd.kind)
      CMD_SPEED_ZERO, CMD_POWER: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt  = PH_IDLE;
          target_nxt = '0;
        end
        motor_nxt   = (cmd.kind == CMD_POWER) ? cmd.power : '0;
        written_nxt = 1'b1;
      end
      CMD_SPEED_SET: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_START;
        end
        target_nxt = cmd.speed;
      end
      CMD_TICK: begin
        case (phase_r)
          PH_START: begin
            phase_nxt       = PH_KICK;
            start_time_nxt  = cmd.now;
            start_count_nxt = cmd.count;
            motor_nxt       = {1'b0, cfg.kick_power};
            updated_nxt     = 1'b1;
          end
          PH_KICK: begin
            if (cmd.count > start_count_r) begin
              phase_nxt   = PH_SETTLE;
              motor_nxt   = {1'b0, cfg.hold_power};
              updated_nxt = 1'b1;
            end
          end
          PH_SETTLE: begin
            if (elapsed > {16'd0, cfg.settle_ms}) begin
              phase_nxt = PH_PID;
              accum_nxt = {motor_r, 8'd0};
            end
          end
          PH_PID: begin
            if (cmd.pid_ready) begin
              accum_nxt   = clamped[16:0];
              motor_nxt   = pid_motor;
              updated_nxt = 1'b1;
            end
          end
          default: ;
        endcase
        written_nxt = updated_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      target_r      <= '0;
      start_time_r  <= '0;
      start_count_r <= '0;
      accum_r       <= '0;
      motor_r       <= '0;
      out_valid_r   <= 1'b0;
      written_r     <= 1'b0;
      updated_r     <= 1'b0;
    end else begin
      if (cmd_pop) begin
        phase_r       <= phase_nxt;
        target_r      <= target_nxt;
        start_time_r  <= start_time_nxt;
        start_count_r <= start_count_nxt;
        accum_r       <= accum_nxt;
        motor_r       <= motor_nxt;
        written_r     <= written_nxt;
        updated_r     <= updated_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

`include "motor_start_pid_sequencer_core_macros.svh"

  // Only a speed outside the zero band leaves idle, and every return to idle clears the target.
  `MSPS_ASSERT_IMPLIES(a_idle_no_target, phase_r == PH_IDLE, target_r == '0)
  `MSPS_ASSERT_ALWAYS(a_motor_range, motor_r != 9'h100)
  `MSPS_ASSERT_IMPLIES(a_tick_flag_writes, updated_r, written_r)

endmodule
`default_nettype wire

>>> hdl/motor_start_pid_sequencer_core.sv
`default_nettype none
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    in_tuser mode, in_tdata item fields
// out_     master     out_tvalid/out_tready  out_tdata result fields
// cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item is accepted per cycle while the queue is not full, and each gives exactly one result.
// Each item is registered in the command queue and then in the output register.
// The state update is an 18-bit add with clamping compares per item.
// Reset is synchronous, active low; configuration returns to its defaults.
// A stalled output fills the queue, after which in_tready drops.
module motor_start_pid_sequencer_core
  import msps_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [1:0] mode
  input  wire logic [1:0]   in_tuser,
  // [31:0] target_speed, [40:32] drive_power, [41] encoder_ok,
  // [73:42] encoder_count, [105:74] now_ms, [106] pid_ready,
  // [123:107] pid_delta, [127:124] zero
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [8:0] motor_power, [9] power_written, [10] tick_updated, [13:11] phase,
  // [45:14] speed_echo, [47:46] zero
  output logic [47:0]       out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  cfg_t cfg_r;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full, q_not_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kick_power <= KICK_POWER_RST;
      cfg_r.hold_power <= HOLD_POWER_RST;
      cfg_r.settle_ms  <= SETTLE_MS_RST;
      cfg_r.zero_band  <= ZERO_BAND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KICK_POWER: cfg_r.kick_power <= cfg_data[7:0];
        REG_HOLD_POWER: cfg_r.hold_power <= cfg_data[7:0];
        REG_SETTLE_MS:  cfg_r.settle_ms  <= cfg_data;
        REG_ZERO_BAND:  cfg_r.zero_band  <= cfg_data;
        default: ;
      endcase
    end
  end

  msps_front u_front (
    .mode      (in_tuser),
    .payload   (in_tdata),
    .zero_band (cfg_r.zero_band),
    .cmd       (front_cmd)
  );

  msps_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  msps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire
